>>> design/rdbl_pkg.sv
// shared types and constants for the risc-v decoder with branch labels
// no dependencies
`default_nettype none
package rdbl_pkg;
    localparam logic [6:0] OP_R      = 7'b0110011;
    localparam logic [6:0] OP_I      = 7'b0010011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [5:0] TOP6_ALT  = 6'b010000;
    localparam logic [5:0] TOP6_ZERO = 6'b000000;

    localparam logic [5:0] CODE_SUB       = 6'd1;
    localparam logic [5:0] CODE_SRA       = 6'd7;
    localparam logic [5:0] CODE_ADDI      = 6'd10;
    localparam logic [5:0] CODE_SLTI      = 6'd11;
    localparam logic [5:0] CODE_SLTIU     = 6'd12;
    localparam logic [5:0] CODE_XORI      = 6'd13;
    localparam logic [5:0] CODE_ORI       = 6'd14;
    localparam logic [5:0] CODE_ANDI      = 6'd15;
    localparam logic [5:0] CODE_SLLI      = 6'd16;
    localparam logic [5:0] CODE_SRLI      = 6'd17;
    localparam logic [5:0] CODE_SRAI      = 6'd18;
    localparam logic [5:0] CODE_LB        = 6'd19;
    localparam logic [5:0] CODE_SB        = 6'd26;
    localparam logic [5:0] CODE_JAL       = 6'd36;
    localparam logic [5:0] CODE_JALR      = 6'd37;
    localparam logic [5:0] CODE_LUI       = 6'd38;
    localparam logic [5:0] CODE_AUIPC     = 6'd39;
    localparam logic [5:0] CODE_BAD_FUNCT = 6'd40;
    localparam logic [5:0] CODE_BAD_OP    = 6'd41;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
    } ctrl_sts_t;

    function automatic logic [5:0] r_code(input logic [2:0] f3);
        case (f3)
            3'd0: r_code = 6'd0;
            3'd1: r_code = 6'd2;
            3'd2: r_code = 6'd3;
            3'd3: r_code = 6'd4;
            3'd4: r_code = 6'd5;
            3'd5: r_code = 6'd6;
            3'd6: r_code = 6'd8;
            default: r_code = 6'd9;
        endcase
    endfunction

    function automatic logic [5:0] b_code(input logic [2:0] f3);
        case (f3)
            3'd0: b_code = 6'd30;
            3'd1: b_code = 6'd31;
            3'd4: b_code = 6'd32;
            3'd5: b_code = 6'd33;
            3'd6: b_code = 6'd34;
            3'd7: b_code = 6'd35;
            default: b_code = CODE_BAD_FUNCT;
        endcase
    endfunction
endpackage
`default_nettype wire

>>> design/riscv_decoder_with_branch_labels_unit.sv
// top level: rv64i decoder with branch-target label table
// depends on rdbl_pkg, rdbl_ctrl, rdbl_datapath
`default_nettype none
// One instruction word in, one decoded word out, in program order; the byte
// address counts up by four from zero after reset. The label table is a
// memory read through one port, one entry per cycle, for both the branch
// target and the word's own address. A new word is taken only in the cycle
// after the previous result has been taken.
module riscv_decoder_with_branch_labels_unit
    import rdbl_pkg::*;
#(
    parameter int LABEL_SLOTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // instruction_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // mnemonic_code[5:0], dest_reg[10:6], src1_reg[15:11], src2_reg[20:16],
    // immediate[41:21], branch_target[73:42], target_label[79:74],
    // target_label_valid[80], table_full[81], here_labelled[82],
    // here_label[88:83], zero fill to 95
    output logic [95:0]      m_tdata
);
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic [5:0]  code, tl, hl;
    logic [4:0]  rd, rs1, rs2;
    logic [20:0] imm;
    logic [31:0] tgt;
    logic        tv, tf, hv;

    rdbl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd(cmd), .sts(sts)
    );

    rdbl_datapath #(.LABEL_SLOTS(LABEL_SLOTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .word_in(s_tdata),
        .mnemonic_code(code), .dest_reg(rd), .src1_reg(rs1), .src2_reg(rs2),
        .immediate(imm), .branch_target(tgt), .target_label(tl),
        .target_label_valid(tv), .table_full(tf),
        .here_labelled(hv), .here_label(hl)
    );

    assign m_tdata = {7'd0, hl, hv, tf, tv, tl, tgt, imm, rs2, rs1, rd, code};
endmodule
`default_nettype wire

>>> design/rdbl_ctrl.sv
// controller for the decoder: sequences load, label scan and output
// depends on rdbl_pkg
`default_nettype none
module rdbl_ctrl
    import rdbl_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output ctrl_cmd_t cmd,
    input  ctrl_sts_t sts
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    cmd.commit = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> design/rdbl_datapath.sv
// decode logic, address counter and label table with one-entry-per-cycle scan
// depends on rdbl_pkg
`default_nettype none
module rdbl_datapath
    import rdbl_pkg::*;
#(
    parameter int LABEL_SLOTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  ctrl_cmd_t        cmd,
    output ctrl_sts_t        sts,
    input  wire logic [31:0] word_in,
    output logic [5:0]       mnemonic_code,
    output logic [4:0]       dest_reg,
    output logic [4:0]       src1_reg,
    output logic [4:0]       src2_reg,
    output logic [20:0]      immediate,
    output logic [31:0]      branch_target,
    output logic [5:0]       target_label,
    output logic             target_label_valid,
    output logic             table_full,
    output logic             here_labelled,
    output logic [5:0]       here_label
);
    localparam int IW = (LABEL_SLOTS > 1) ? $clog2(LABEL_SLOTS) : 1;
    localparam int CW = $clog2(LABEL_SLOTS + 1);

    logic [31:0] mem [LABEL_SLOTS];
    logic [31:0] word_reg, addr_reg, rd_data_reg;
    logic [CW-1:0] count_reg, scan_reg;
    logic          rd_ok_reg;
    logic          t_hit_reg, h_hit_reg;
    logic [CW-1:0] t_idx_reg, h_idx_reg;

    logic [31:0] w;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  top6;
    logic [5:0]  code;
    logic [4:0]  o_rd, o_rs1, o_rs2;
    logic [20:0] imm;
    logic        is_jump;
    logic [31:0] target;

    assign w    = word_reg;
    assign op   = w[6:0];
    assign f3   = w[14:12];
    assign f7   = w[31:25];
    assign top6 = w[31:26];

    always_comb begin
        code = CODE_BAD_OP;
        o_rd = '0;
        o_rs1 = '0;
        o_rs2 = '0;
        imm = '0;
        is_jump = 1'b0;
        case (op)
            OP_R: begin
                o_rd = w[11:7]; o_rs1 = w[19:15]; o_rs2 = w[24:20];
                if (f3 == 3'd0 && f7 == F7_ALT) code = CODE_SUB;
                else if (f3 == 3'd5 && f7 == F7_ALT) code = CODE_SRA;
                else if (f7 != 7'd0) code = CODE_BAD_FUNCT;
                else code = r_code(f3);
            end
            OP_I: begin
                o_rd = w[11:7]; o_rs1 = w[19:15];
                imm = {{9{w[31]}}, w[31:20]};
                case (f3)
                    3'd0: code = CODE_ADDI;
                    3'd2: code = CODE_SLTI;
                    3'd3: code = CODE_SLTIU;
                    3'd4: code = CODE_XORI;
                    3'd6: code = CODE_ORI;
                    3'd7: code = CODE_ANDI;
                    3'd1: code = (top6 == TOP6_ZERO) ? CODE_SLLI : CODE_BAD_FUNCT;
                    default: begin
                        if (top6 == TOP6_ZERO) code = CODE_SRLI;
                        else if (top6 == TOP6_ALT) code = CODE_SRAI;
                        else code = CODE_BAD_FUNCT;
                        imm = {15'd0, w[25:20]};
                    end
                endcase
            end
            OP_LOAD: begin
                o_rd = w[11:7]; o_rs1 = w[19:15];
                imm = {{9{w[31]}}, w[31:20]};
                code = (f3 != 3'd7) ? CODE_LB + {3'd0, f3} : CODE_BAD_FUNCT;
            end
            OP_STORE: begin
                o_rs1 = w[19:15]; o_rs2 = w[24:20];
                imm = {{9{w[31]}}, w[31:25], w[11:7]};
                code = (f3[2] == 1'b0) ? CODE_SB + {4'd0, f3[1:0]} : CODE_BAD_FUNCT;
            end
            OP_BRANCH: begin
                o_rs1 = w[19:15]; o_rs2 = w[24:20];
                imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                code = b_code(f3);
                is_jump = 1'b1;
            end
            OP_JAL: begin
                o_rd = w[11:7];
                imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
                code = CODE_JAL;
                is_jump = 1'b1;
            end
            OP_JALR: begin
                o_rd = w[11:7]; o_rs1 = w[19:15];
                imm = {{9{w[31]}}, w[31:20]};
                code = (f3 == 3'd0) ? CODE_JALR : CODE_BAD_FUNCT;
            end
            OP_LUI: begin
                o_rd = w[11:7]; imm = {1'b0, w[31:12]}; code = CODE_LUI;
            end
            OP_AUIPC: begin
                o_rd = w[11:7]; imm = {1'b0, w[31:12]}; code = CODE_AUIPC;
            end
            default: code = CODE_BAD_OP;
        endcase
    end

    assign target = addr_reg + {{11{imm[20]}}, imm};

    // memory read pipelined: rd_data_reg holds entry scan_reg-1
    logic [CW-1:0] chk_idx;
    logic          last_read;
    assign chk_idx   = scan_reg - CW'(1);
    assign last_read = (scan_reg >= count_reg);
    assign sts.scan_done = last_read && !rd_ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg <= word_in;
        end
        rd_data_reg <= mem[scan_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg  <= '0;
            rd_ok_reg <= 1'b0;
            t_hit_reg <= 1'b0;
            h_hit_reg <= 1'b0;
            t_idx_reg <= '0;
            h_idx_reg <= '0;
        end else if (cmd.load) begin
            scan_reg  <= '0;
            rd_ok_reg <= 1'b0;
            t_hit_reg <= 1'b0;
            h_hit_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            rd_ok_reg <= !last_read;
            if (!last_read) begin
                scan_reg <= scan_reg + CW'(1);
            end
            if (rd_ok_reg) begin
                if (!t_hit_reg && rd_data_reg == target) begin
                    t_hit_reg <= 1'b1;
                    t_idx_reg <= chk_idx;
                end
                if (!h_hit_reg && rd_data_reg == addr_reg) begin
                    h_hit_reg <= 1'b1;
                    h_idx_reg <= chk_idx;
                end
            end
        end
    end

    // output registers and table update at commit
    logic          new_label;
    assign new_label = is_jump && !t_hit_reg && (count_reg < CW'(LABEL_SLOTS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg  <= '0;
            count_reg <= '0;
        end else if (cmd.commit) begin
            addr_reg <= addr_reg + 32'd4;
            if (new_label) count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && new_label) begin
            mem[count_reg[IW-1:0]] <= target;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mnemonic_code      <= '0;
            dest_reg           <= '0;
            src1_reg           <= '0;
            src2_reg           <= '0;
            immediate          <= '0;
            branch_target      <= '0;
            target_label       <= '0;
            target_label_valid <= 1'b0;
            table_full         <= 1'b0;
            here_labelled      <= 1'b0;
            here_label         <= '0;
        end else if (cmd.commit) begin
            mnemonic_code <= code;
            if (code >= CODE_BAD_FUNCT) begin
                dest_reg <= '0; src1_reg <= '0; src2_reg <= '0; immediate <= '0;
            end else begin
                dest_reg <= o_rd; src1_reg <= o_rs1; src2_reg <= o_rs2; immediate <= imm;
            end
            branch_target      <= is_jump ? target : 32'd0;
            target_label_valid <= is_jump && (t_hit_reg || new_label);
            table_full         <= is_jump && !t_hit_reg && !new_label;
            if (is_jump && t_hit_reg) target_label <= t_idx_reg[5:0];
            else if (new_label) target_label <= count_reg[5:0];
            else target_label <= '0;
            // own address may have just been labelled by this item
            if (h_hit_reg) begin
                here_labelled <= 1'b1;
                here_label    <= h_idx_reg[5:0];
            end else if (new_label && target == addr_reg) begin
                here_labelled <= 1'b1;
                here_label    <= count_reg[5:0];
            end else begin
                here_labelled <= 1'b0;
                here_label    <= '0;
            end
        end
    end
endmodule
`default_nettype wire

>>> design/rdbl_checker.sv
// port-level checks for the decoder top level, with bind
// depends on riscv_decoder_with_branch_labels_unit
`default_nettype none
module rdbl_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input ready while result held");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_valid_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[80] && m_tdata[81])) else $error("label and full");
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[5:0] <= 6'd41) else $error("bad code");
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("double accept");
endmodule

bind riscv_decoder_with_branch_labels_unit rdbl_checker u_rdbl_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

>>> dv/tb_riscv_decoder_with_branch_labels_unit.sv
// self-checking testbench for the rv64i decoder with branch-target labels
// depends on rdbl_pkg and riscv_decoder_with_branch_labels_unit
`default_nettype none
module tb_riscv_decoder_with_branch_labels_unit;
    import rdbl_pkg::*;

    localparam int SLOTS = 64;
    localparam int STALL_LIMIT = 20000;

    // packed from the top bit down, so code lands in the lowest bits
    typedef struct packed {
        logic [5:0]  hlabel;
        logic        here;
        logic        full;
        logic        tvalid;
        logic [5:0]  tlabel;
        logic [31:0] target;
        logic [20:0] imm;
        logic [4:0]  rs2;
        logic [4:0]  rs1;
        logic [4:0]  rd;
        logic [5:0]  code;
    } decoded_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;

    // predictor state
    logic [31:0] pc_addr;
    logic [31:0] label_addr [SLOTS];
    int          label_cnt;

    decoded_t    expected_q [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          quiet_cycles = 0;

    riscv_decoder_with_branch_labels_unit #(.LABEL_SLOTS(SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [31:0] sign_ext(input logic [31:0] x, input int bits);
        logic [31:0] m;
        m = 32'd1 << (bits - 1);
        return (x ^ m) - m;
    endfunction

    function automatic int label_of(input logic [31:0] a);
        for (int k = 0; k < label_cnt; k++)
            if (label_addr[k] == a) return k;
        return -1;
    endfunction

    function automatic decoded_t decode_word(input logic [31:0] w);
        decoded_t    d;
        logic [6:0]  op;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [5:0]  top6;
        logic [31:0] imm;
        logic        jump;
        int          idx;
        d = '0;
        op = w[6:0];
        f3 = w[14:12];
        f7 = w[31:25];
        top6 = w[31:26];
        imm = '0;
        jump = 1'b0;
        d.code = CODE_BAD_OP;
        case (op)
            OP_R: begin
                d.rd = w[11:7]; d.rs1 = w[19:15]; d.rs2 = w[24:20];
                if (f3 == 3'd0 && f7 == F7_ALT) d.code = CODE_SUB;
                else if (f3 == 3'd5 && f7 == F7_ALT) d.code = CODE_SRA;
                else if (f7 != 7'd0) d.code = CODE_BAD_FUNCT;
                else begin
                    case (f3)
                        3'd0: d.code = 6'd0;
                        3'd1: d.code = 6'd2;
                        3'd2: d.code = 6'd3;
                        3'd3: d.code = 6'd4;
                        3'd4: d.code = 6'd5;
                        3'd5: d.code = 6'd6;
                        3'd6: d.code = 6'd8;
                        default: d.code = 6'd9;
                    endcase
                end
            end
            OP_I: begin
                d.rd = w[11:7]; d.rs1 = w[19:15];
                imm = sign_ext({20'd0, w[31:20]}, 12);
                case (f3)
                    3'd0: d.code = CODE_ADDI;
                    3'd2: d.code = CODE_SLTI;
                    3'd3: d.code = CODE_SLTIU;
                    3'd4: d.code = CODE_XORI;
                    3'd6: d.code = CODE_ORI;
                    3'd7: d.code = CODE_ANDI;
                    3'd1: d.code = (top6 == TOP6_ZERO) ? CODE_SLLI : CODE_BAD_FUNCT;
                    default: begin
                        if (top6 == TOP6_ZERO) d.code = CODE_SRLI;
                        else if (top6 == TOP6_ALT) d.code = CODE_SRAI;
                        else d.code = CODE_BAD_FUNCT;
                        // shift amount is unsigned
                        imm = {26'd0, w[25:20]};
                    end
                endcase
            end
            OP_LOAD: begin
                d.rd = w[11:7]; d.rs1 = w[19:15];
                imm = sign_ext({20'd0, w[31:20]}, 12);
                d.code = (f3 < 3'd7) ? CODE_LB + {3'd0, f3} : CODE_BAD_FUNCT;
            end
            OP_STORE: begin
                d.rs1 = w[19:15]; d.rs2 = w[24:20];
                imm = sign_ext({20'd0, f7, w[11:7]}, 12);
                d.code = (f3 < 3'd4) ? CODE_SB + {3'd0, f3} : CODE_BAD_FUNCT;
            end
            OP_BRANCH: begin
                d.rs1 = w[19:15]; d.rs2 = w[24:20];
                imm = sign_ext({19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
                case (f3)
                    3'd0: d.code = 6'd30;
                    3'd1: d.code = 6'd31;
                    3'd4: d.code = 6'd32;
                    3'd5: d.code = 6'd33;
                    3'd6: d.code = 6'd34;
                    3'd7: d.code = 6'd35;
                    default: d.code = CODE_BAD_FUNCT;
                endcase
                jump = 1'b1;
            end
            OP_JAL: begin
                d.rd = w[11:7];
                imm = sign_ext({11'd0, w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
                d.code = CODE_JAL;
                jump = 1'b1;
            end
            OP_JALR: begin
                d.rd = w[11:7]; d.rs1 = w[19:15];
                imm = sign_ext({20'd0, w[31:20]}, 12);
                d.code = (f3 == 3'd0) ? CODE_JALR : CODE_BAD_FUNCT;
            end
            OP_LUI: begin
                d.rd = w[11:7]; imm = {12'd0, w[31:12]}; d.code = CODE_LUI;
            end
            OP_AUIPC: begin
                d.rd = w[11:7]; imm = {12'd0, w[31:12]}; d.code = CODE_AUIPC;
            end
            default: ;
        endcase
        if (jump) begin
            d.target = pc_addr + imm;
            idx = label_of(d.target);
            if (idx >= 0) begin
                d.tlabel = idx[5:0]; d.tvalid = 1'b1;
            end else if (label_cnt < SLOTS) begin
                label_addr[label_cnt] = d.target;
                d.tlabel = label_cnt[5:0]; d.tvalid = 1'b1;
                label_cnt++;
            end else begin
                d.full = 1'b1;
            end
        end
        // a bad code hides the register and immediate fields, but the target stays
        if (d.code >= CODE_BAD_FUNCT) begin
            d.rd = '0; d.rs1 = '0; d.rs2 = '0; imm = '0;
        end
        d.imm = imm[20:0];
        idx = label_of(pc_addr);
        d.here = (idx >= 0);
        d.hlabel = (idx >= 0) ? idx[5:0] : 6'd0;
        pc_addr += 32'd4;
        return d;
    endfunction

    // tvalid stays up between words unless the sender idles
    task automatic send_word(input logic [31:0] w);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.insert(expected_q.size(), decode_word(w));
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
    endtask

    // receiver stall pattern
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        decoded_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = decoded_t'(m_tdata[88:0]);
            if (expected_q.size() == 0) begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.code != want.code) begin
                    $error("mnemonic_code exp %0d got %0d", want.code, got.code); errors++;
                end
                if (got.rd != want.rd) begin
                    $error("dest_reg exp %0d got %0d", want.rd, got.rd); errors++;
                end
                if (got.rs1 != want.rs1) begin
                    $error("src1_reg exp %0d got %0d", want.rs1, got.rs1); errors++;
                end
                if (got.rs2 != want.rs2) begin
                    $error("src2_reg exp %0d got %0d", want.rs2, got.rs2); errors++;
                end
                if (got.imm != want.imm) begin
                    $error("immediate exp %h got %h", want.imm, got.imm); errors++;
                end
                if (got.target != want.target) begin
                    $error("branch_target exp %h got %h", want.target, got.target); errors++;
                end
                if (got.tlabel != want.tlabel) begin
                    $error("target_label exp %0d got %0d", want.tlabel, got.tlabel); errors++;
                end
                if (got.tvalid != want.tvalid) begin
                    $error("target_label_valid exp %0b got %0b", want.tvalid, got.tvalid);
                    errors++;
                end
                if (got.full != want.full) begin
                    $error("table_full exp %0b got %0b", want.full, got.full); errors++;
                end
                if (got.here != want.here) begin
                    $error("here_labelled exp %0b got %0b", want.here, got.here); errors++;
                end
                if (got.hlabel != want.hlabel) begin
                    $error("here_label exp %0d got %0d", want.hlabel, got.hlabel); errors++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_branch(input logic [12:0] off);
        logic [31:0] w;
        w = $urandom;
        w[6:0] = OP_BRANCH;
        w[31] = off[12]; w[7] = off[11]; w[30:25] = off[10:5]; w[11:8] = off[4:1];
        return w;
    endfunction

    function automatic logic [31:0] rand_jal(input logic [20:0] off);
        logic [31:0] w;
        w = $urandom;
        w[6:0] = OP_JAL;
        w[31] = off[20]; w[19:12] = off[19:12]; w[20] = off[11]; w[30:21] = off[10:1];
        return w;
    endfunction

    function automatic logic [31:0] rand_form;
        logic [31:0] w;
        logic [6:0]  ops [9];
        w = $urandom;
        ops = '{OP_R, OP_I, OP_LOAD, OP_STORE, OP_BRANCH, OP_JAL, OP_JALR, OP_LUI,
                OP_AUIPC};
        w[6:0] = ops[$urandom_range(8)];
        case ($urandom_range(3))
            0: w[31:25] = 7'd0;
            1: w[31:25] = F7_ALT;
            default: ;
        endcase
        return w;
    endfunction

    task automatic test_directed_forms;
        send_word({7'd0, 5'd31, 5'd31, 3'd0, 5'd31, OP_R});
        send_word({F7_ALT, 5'd1, 5'd2, 3'd0, 5'd3, OP_R});
        send_word({F7_ALT, 5'd1, 5'd2, 3'd5, 5'd3, OP_R});
        send_word({F7_ALT, 5'd1, 5'd2, 3'd1, 5'd3, OP_R});
        for (int f = 0; f < 8; f++) send_word({7'd0, 5'd4, 5'd5, f[2:0], 5'd6, OP_R});
        send_word({12'h800, 5'd1, 3'd0, 5'd2, OP_I});
        send_word({12'h7ff, 5'd1, 3'd2, 5'd2, OP_I});
        send_word({TOP6_ALT, 6'h3f, 5'd1, 3'd5, 5'd2, OP_I});
        send_word({TOP6_ZERO, 6'h3f, 5'd1, 3'd5, 5'd2, OP_I});
        send_word({6'h3f, 6'h20, 5'd1, 3'd1, 5'd2, OP_I});
        send_word({12'hfff, 5'd1, 3'd7, 5'd2, OP_LOAD});
        send_word({7'h7f, 5'd1, 5'd2, 3'd3, 5'h1f, OP_STORE});
        send_word({7'h7f, 5'd1, 5'd2, 3'd4, 5'h1f, OP_STORE});
        send_word({12'h123, 5'd1, 3'd1, 5'd2, OP_JALR});
        send_word({20'hfffff, 5'd0, OP_LUI});
        send_word({20'hfffff, 5'd7, OP_AUIPC});
        send_word(32'h0000_0073);              // system call is a bad opcode
        send_word(32'hffff_ffff);
        drain();
    endtask

    task automatic test_directed_labels;
        send_word(rand_branch(13'h1000));      // most negative offset wraps below zero
        send_word(rand_jal(21'h0fffff & ~21'd1));
        send_word(rand_branch(13'd8) & ~(32'd7 << 12) | (32'd2 << 12));  // bad funct3
        send_word(rand_jal(21'd0));            // target is its own address
        send_word(rand_branch(13'h1ffc));      // backwards onto an already-seen address
        drain();
    endtask

    task automatic test_random(input int n);
        int off;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    // short offsets so targets land on nearby earlier and later words and reuse labels
                    off = $urandom_range(16) * 4 - 24;
                    if ($urandom_range(1)) send_word(rand_branch(off[12:0]));
                    else send_word(rand_jal(off[20:0]));
                end
                4: send_word($urandom);
                default: send_word(rand_form());
            endcase
            // wait out the outstanding result now and then
            if ($urandom_range(199) == 0) drain();
        end
        drain();
    endtask

    initial begin
        label_cnt = 0;
        pc_addr = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 24; recv_idle_pct = 70;
        test_directed_forms();
        test_directed_labels();
        test_random(580);
        send_idle_pct = 70; recv_idle_pct = 24;
        test_random(580);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(560);
        repeat (100) @(negedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
